// File: rtl/core/alc_pkg.sv
// ----------------------------------------------------------------------------
// alc_pkg
// Shared types and constants for the ambient light level classifier.
// ----------------------------------------------------------------------------
package alc_pkg;

	localparam int MV_W  = 12;
	localparam int SUM_W = 16;
	localparam int CNT_W = 4;
	localparam int IDX_W = 2;

	// Reading kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_FORCE  = 1'b1;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_HIGH_THR   = 2'd0;
	localparam logic [IDX_W-1:0] REG_LOW_THR    = 2'd1;
	localparam logic [IDX_W-1:0] REG_CHANGE_TOL = 2'd2;

	// Register reset values
	localparam logic [MV_W-1:0] HIGH_THR_RST   = 12'h1F4;
	localparam logic [MV_W-1:0] LOW_THR_RST    = 12'h03C;
	localparam logic [MV_W-1:0] CHANGE_TOL_RST = 12'd10;

	typedef enum logic [1:0] {
		LVL_LOW    = 2'd0,
		LVL_NORMAL = 2'd1,
		LVL_HIGH   = 2'd2,
		LVL_NONE   = 2'd3   // nothing reported since reset
	} level_t;

	typedef struct packed {
		logic [MV_W-1:0] high_thr;
		logic [MV_W-1:0] low_thr;
		logic [MV_W-1:0] change_tol;
	} cfg_t;

	typedef struct packed {
		logic            emit;
		level_t          level;
		logic [MV_W-1:0] avg;
	} result_t;

endpackage

// File: rtl/core/ambient_light_level_classifier_top.sv
// ----------------------------------------------------------------------------
// ambient_light_level_classifier_top
// Averages light-sensor readings and reports ambient light class changes.
// ----------------------------------------------------------------------------
// One beat in per clock while in_stall is low: a reading or force event is
// captured in an input register and fully evaluated from there (sum, divide
// by the sample count through a constant reciprocal multiply, tolerance
// check, classification). The single multiply feeding the compares is the
// critical path. Each input beat yields zero or one result beat; a result
// sits in an output register while the input side keeps flowing, and the input
// stalls only when both the input register and a stalled output register are
// full. Thresholds and tolerance are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle, which the block
// itself does not enforce. Writes to index three are dropped.
// ----------------------------------------------------------------------------
module ambient_light_level_classifier_top #(
	parameter int SAMPLES_PER_AVERAGE = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input beats
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic [alc_pkg::MV_W-1:0]    sample_mv,
	// result beats
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  light_level,
	output logic [alc_pkg::MV_W-1:0]    average_mv,
	// configuration writes
	input  logic                        cfg_we,
	input  logic [alc_pkg::IDX_W-1:0]   cfg_index,
	input  logic [alc_pkg::MV_W-1:0]    cfg_data
);

	alc_pkg::cfg_t    cfg;
	alc_pkg::result_t res;

	logic                     valid_s1;
	logic                     kind_s1;
	logic [alc_pkg::MV_W-1:0] sample_s1;
	logic                     advance;
	logic                     step;
	logic                     out_valid_q;
	alc_pkg::level_t          level_q;
	logic [alc_pkg::MV_W-1:0] avg_q;

	// Register stage: the output register has room, or will have it this cycle
	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	// Hold the input while the captured beat cannot move on
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1   <= kind;
			sample_s1 <= sample_mv;
		end
	end

	alc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	alc_engine #(
		.SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.kind      (kind_s1),
		.sample_mv (sample_s1),
		.cfg       (cfg),
		.res       (res)
	);

	// Result register: load on a new result, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.emit) begin
			level_q <= res.level;
			avg_q   <= res.avg;
		end
	end

	assign out_valid   = out_valid_q;
	assign light_level = level_q;
	assign average_mv  = avg_q;

endmodule

// File: rtl/core/alc_cfg_regs.sv
// ----------------------------------------------------------------------------
// alc_cfg_regs
// Threshold and tolerance registers behind the plain write port.
// ----------------------------------------------------------------------------
module alc_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [alc_pkg::IDX_W-1:0]   cfg_index,
	input  logic [alc_pkg::MV_W-1:0]    cfg_data,
	output alc_pkg::cfg_t               cfg
);

	alc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_thr   <= alc_pkg::HIGH_THR_RST;
			cfg_q.low_thr    <= alc_pkg::LOW_THR_RST;
			cfg_q.change_tol <= alc_pkg::CHANGE_TOL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				alc_pkg::REG_HIGH_THR:   cfg_q.high_thr   <= cfg_data;
				alc_pkg::REG_LOW_THR:    cfg_q.low_thr    <= cfg_data;
				alc_pkg::REG_CHANGE_TOL: cfg_q.change_tol <= cfg_data;
				default: ;  // drop writes to unused indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/alc_engine.sv
// ----------------------------------------------------------------------------
// alc_engine
// Averaging state and combinational decision: run start, sum, divide,
// re-evaluate, classify and report.
// ----------------------------------------------------------------------------
module alc_engine #(
	parameter int SAMPLES_PER_AVERAGE = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        kind,
	input  logic [alc_pkg::MV_W-1:0]    sample_mv,
	input  alc_pkg::cfg_t               cfg,
	output alc_pkg::result_t            res
);

	localparam int SPA_EFF = (SAMPLES_PER_AVERAGE < 1) ? 1 :
		((SAMPLES_PER_AVERAGE > 16) ? 16 : SAMPLES_PER_AVERAGE);
	// Reciprocal is exact for every 16-bit sum and divisor up to 16.
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = alc_pkg::SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + SPA_EFF - 1) / SPA_EFF);
	localparam logic [alc_pkg::CNT_W:0] SPA_CNT = (alc_pkg::CNT_W+1)'(SPA_EFF);

	logic [alc_pkg::MV_W-1:0]  acc_avg_q;
	alc_pkg::level_t           reported_q;
	logic                      force_q;
	logic                      active_q;
	logic [alc_pkg::SUM_W-1:0] sum_q;
	logic [alc_pkg::CNT_W-1:0] cnt_q;

	logic [alc_pkg::MV_W-1:0]  diff_in;
	logic [alc_pkg::MV_W-1:0]  diff_avg;
	logic                      is_sample;
	logic                      start;
	logic                      proceed;
	logic [alc_pkg::SUM_W-1:0] sum_base;
	logic [alc_pkg::SUM_W-1:0] sum_new;
	logic [alc_pkg::CNT_W-1:0] cnt_base;
	logic [alc_pkg::CNT_W:0]   cnt_next;
	logic                      finish;
	logic [PROD_W-1:0]         prod;
	logic [alc_pkg::MV_W-1:0]  avg;
	logic                      take_avg;
	alc_pkg::level_t           level;
	logic                      emit;

	always_comb begin
		diff_in  = (sample_mv > acc_avg_q) ? sample_mv - acc_avg_q : acc_avg_q - sample_mv;
		is_sample = (kind == alc_pkg::KIND_SAMPLE);
		start    = !active_q && (force_q || (diff_in > cfg.change_tol));
		proceed  = is_sample && (active_q || start);
		sum_base = active_q ? sum_q : '0;
		cnt_base = active_q ? cnt_q : '0;
		sum_new  = sum_base + alc_pkg::SUM_W'(sample_mv);
		cnt_next = {1'b0, cnt_base} + 1'b1;
		finish   = proceed && (cnt_next >= SPA_CNT);

		prod = {{RECIP_W{1'b0}}, sum_new} * {{alc_pkg::SUM_W{1'b0}}, RECIP};
		avg  = prod[RECIP_SHIFT +: alc_pkg::MV_W];

		diff_avg = (avg > acc_avg_q) ? avg - acc_avg_q : acc_avg_q - avg;
		take_avg = force_q || (diff_avg > cfg.change_tol);

		// High test first: crossed thresholds classify as high
		if (avg >= cfg.high_thr) begin
			level = alc_pkg::LVL_HIGH;
		end else if (avg < cfg.low_thr) begin
			level = alc_pkg::LVL_LOW;
		end else begin
			level = alc_pkg::LVL_NORMAL;
		end

		emit = finish && take_avg && (force_q || (level != reported_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_avg_q  <= '0;
			reported_q <= alc_pkg::LVL_NONE;
			force_q    <= 1'b0;
			active_q   <= 1'b0;
			sum_q      <= '0;
			cnt_q      <= '0;
		end else if (step) begin
			if (!is_sample) begin
				force_q <= 1'b1;
			end else if (finish) begin
				active_q <= 1'b0;
				sum_q    <= '0;
				cnt_q    <= '0;
				if (take_avg) begin
					acc_avg_q <= avg;
				end
				if (emit) begin
					force_q    <= 1'b0;
					reported_q <= level;
				end
			end else if (proceed) begin
				active_q <= 1'b1;
				sum_q    <= sum_new;
				cnt_q    <= cnt_next[alc_pkg::CNT_W-1:0];
			end
		end
	end

	assign res.emit  = step && emit;
	assign res.level = level;
	assign res.avg   = avg;

endmodule

// File: rtl/core/alc_checker.sv
// ----------------------------------------------------------------------------
// alc_checker
// Port-level checks for the ambient light level classifier.
// ----------------------------------------------------------------------------
module alc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        kind,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [1:0]                  light_level,
	input logic [alc_pkg::MV_W-1:0]    average_mv
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(light_level) && $stable(average_mv))
		else $error("stalled result beat changed");

	// Reported class is always low, normal or high
	a_level_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> light_level != alc_pkg::LVL_NONE)
		else $error("result carries no class");

	// An empty output register never stalls the input
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// A fresh result comes from an accepted sample reading that passed through the input register into the result register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && kind == alc_pkg::KIND_SAMPLE, 2))
		else $error("result without a matching reading");

endmodule

bind ambient_light_level_classifier_top alc_checker u_alc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.kind        (kind),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.light_level (light_level),
	.average_mv  (average_mv)
);
